FILE: rtl/su3_pkg.sv
package su3_pkg;

   // Number format: signed two's complement, Q3.20 by default
   localparam int VALUE_BITS = 24;
   localparam int FRAC_BITS  = 20;

   // Matrix geometry
   localparam int NUM_ROWS = 3;
   localparam int ROW_W    = 2;
   localparam int CMD_W    = 2;

   // Datapath widths: full product, pair sum, sum of six products
   localparam int PROD_W = 2 * VALUE_BITS;
   localparam int SUM_W  = PROD_W + 1;
   localparam int ACC_W  = PROD_W + 3;
   localparam int SH_W   = ACC_W - FRAC_BITS;

   // Pipeline and result queue sizing
   localparam int CELL_STAGES = 3;
   localparam int RSP_LATENCY = NUM_ROWS * CELL_STAGES + 1;
   localparam int RSP_DEPTH   = 16;
   localparam int PTR_W       = $clog2(RSP_DEPTH);
   localparam int CNT_W       = $clog2(RSP_DEPTH + 1);

   typedef logic signed [VALUE_BITS-1:0] val_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [ACC_W-1:0]      acc_word_type;
   typedef logic [ROW_W-1:0]             row_type;
   typedef logic [PTR_W-1:0]             ptr_type;
   typedef logic [CNT_W-1:0]             cnt_type;

   localparam val_type VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_MUL  = 2'd1,
      CMD_DAG  = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef struct packed {
      val_type re;
      val_type im;
   } cplx_type;

   typedef cplx_type [NUM_ROWS-1:0] cvec_type;

   typedef struct packed {
      acc_word_type re;
      acc_word_type im;
   } acc_type;

   typedef acc_type [NUM_ROWS-1:0] acc_vec_type;

   // Request as it travels down the cell chain
   typedef struct packed {
      cmd_type  cmd;
      row_type  row;
      cvec_type vec;
      logic     last;
   } tok_type;

   typedef struct packed {
      cvec_type y;
      logic     last;
   } rsp_type;

   // Floor shift by FRAC_BITS, then clamp to the value range
   function automatic val_type sat_q(input acc_word_type a);
      logic signed [SH_W-1:0]         sh;
      logic [SH_W-VALUE_BITS:0]       hi;
      val_type                        res;
      sh = SH_W'(a >>> FRAC_BITS);
      hi = sh[SH_W-1:VALUE_BITS-1];
      if ((&hi) || (~|hi)) begin
         res = val_type'(sh[VALUE_BITS-1:0]);
      end else if (sh[SH_W-1]) begin
         res = VAL_MIN;
      end else begin
         res = VAL_MAX;
      end
      return res;
   endfunction

endpackage

FILE: rtl/su3_if.sv
// Request channel: one load, multiply or conjugate-transpose multiply request
interface su3_req_if;
   logic                     valid;
   logic                     ready;
   logic [su3_pkg::CMD_W-1:0] cmd;
   logic [su3_pkg::ROW_W-1:0] row;
   su3_pkg::val_type          a_re;
   su3_pkg::val_type          a_im;
   su3_pkg::val_type          b_re;
   su3_pkg::val_type          b_im;
   su3_pkg::val_type          c_re;
   su3_pkg::val_type          c_im;
   logic                      last_in;

   modport source (
      output valid, cmd, row, a_re, a_im, b_re, b_im, c_re, c_im, last_in,
      input  ready
   );
   modport sink (
      input  valid, cmd, row, a_re, a_im, b_re, b_im, c_re, c_im, last_in,
      output ready
   );
endinterface

// Result channel: one complex 3-vector per multiply request
interface su3_rsp_if;
   logic             valid;
   logic             ready;
   su3_pkg::val_type y1_re;
   su3_pkg::val_type y1_im;
   su3_pkg::val_type y2_re;
   su3_pkg::val_type y2_im;
   su3_pkg::val_type y3_re;
   su3_pkg::val_type y3_im;
   logic             last_out;

   modport source (
      output valid, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im, last_out,
      input  ready
   );
   modport sink (
      input  valid, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im, last_out,
      output ready
   );
endinterface

FILE: rtl/su3_cell.sv
// One matrix row and its share of the multiply. Requests pass through in
// three stages: products, pair sums, accumulate. A load for this row updates
// the row as the load passes, so order against later requests is kept.
module su3_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  su3_pkg::row_type     cell_idx,
   input  logic                 vld_i,
   input  su3_pkg::tok_type     tok_i,
   input  su3_pkg::acc_vec_type acc_i,
   output logic                 vld_o,
   output su3_pkg::tok_type     tok_o,
   output su3_pkg::acc_vec_type acc_o
);

   su3_pkg::cvec_type    row_ff, row_in;

   logic                 v1_ff, v2_ff, v3_ff;
   su3_pkg::tok_type     tok1_ff, tok2_ff, tok3_ff;
   su3_pkg::acc_vec_type acc1_ff, acc2_ff, acc3_ff, acc3_in;

   su3_pkg::val_type     u_re [su3_pkg::NUM_ROWS];
   su3_pkg::val_type     u_im [su3_pkg::NUM_ROWS];
   su3_pkg::prod_type    pa_ff [su3_pkg::NUM_ROWS], pa_in [su3_pkg::NUM_ROWS];
   su3_pkg::prod_type    pb_ff [su3_pkg::NUM_ROWS], pb_in [su3_pkg::NUM_ROWS];
   su3_pkg::prod_type    pc_ff [su3_pkg::NUM_ROWS], pc_in [su3_pkg::NUM_ROWS];
   su3_pkg::prod_type    pd_ff [su3_pkg::NUM_ROWS], pd_in [su3_pkg::NUM_ROWS];
   su3_pkg::sum_type     sre_ff [su3_pkg::NUM_ROWS], sre_in [su3_pkg::NUM_ROWS];
   su3_pkg::sum_type     sim_ff [su3_pkg::NUM_ROWS], sim_in [su3_pkg::NUM_ROWS];
   su3_pkg::acc_word_type tot_re, tot_im;

   // Row update and stage 1 products
   // multiply: row element j pairs with vector element j
   // dagger:   row element j pairs with vector element of this row
   always_comb begin
      row_in = row_ff;
      if (vld_i && (tok_i.cmd == su3_pkg::CMD_LOAD) && (tok_i.row == cell_idx)) begin
         row_in = tok_i.vec;
      end
      for (int j = 0; j < su3_pkg::NUM_ROWS; j++) begin
         if (tok_i.cmd == su3_pkg::CMD_DAG) begin
            u_re[j] = tok_i.vec[cell_idx].re;
            u_im[j] = tok_i.vec[cell_idx].im;
         end else begin
            u_re[j] = tok_i.vec[j].re;
            u_im[j] = tok_i.vec[j].im;
         end
         pa_in[j] = row_ff[j].re * u_re[j];
         pb_in[j] = row_ff[j].im * u_im[j];
         pc_in[j] = row_ff[j].re * u_im[j];
         pd_in[j] = row_ff[j].im * u_re[j];
      end
   end

   // Stage 2: combine product pairs (sign of the imaginary terms by mode)
   always_comb begin
      for (int j = 0; j < su3_pkg::NUM_ROWS; j++) begin
         if (tok1_ff.cmd == su3_pkg::CMD_MUL) begin
            sre_in[j] = su3_pkg::sum_type'(pa_ff[j]) - su3_pkg::sum_type'(pb_ff[j]);
            sim_in[j] = su3_pkg::sum_type'(pc_ff[j]) + su3_pkg::sum_type'(pd_ff[j]);
         end else begin
            sre_in[j] = su3_pkg::sum_type'(pa_ff[j]) + su3_pkg::sum_type'(pb_ff[j]);
            sim_in[j] = su3_pkg::sum_type'(pc_ff[j]) - su3_pkg::sum_type'(pd_ff[j]);
         end
      end
   end

   // Stage 3: add into the running result vector
   always_comb begin
      acc3_in = acc2_ff;
      tot_re  = su3_pkg::acc_word_type'(sre_ff[0]) + su3_pkg::acc_word_type'(sre_ff[1])
              + su3_pkg::acc_word_type'(sre_ff[2]);
      tot_im  = su3_pkg::acc_word_type'(sim_ff[0]) + su3_pkg::acc_word_type'(sim_ff[1])
              + su3_pkg::acc_word_type'(sim_ff[2]);
      case (tok2_ff.cmd)
         su3_pkg::CMD_MUL: begin
            acc3_in[cell_idx].re = acc2_ff[cell_idx].re + tot_re;
            acc3_in[cell_idx].im = acc2_ff[cell_idx].im + tot_im;
         end
         su3_pkg::CMD_DAG: begin
            for (int i = 0; i < su3_pkg::NUM_ROWS; i++) begin
               acc3_in[i].re = acc2_ff[i].re + su3_pkg::acc_word_type'(sre_ff[i]);
               acc3_in[i].im = acc2_ff[i].im + su3_pkg::acc_word_type'(sim_ff[i]);
            end
         end
         default: begin
            acc3_in = acc2_ff;
         end
      endcase
   end

   // Control and matrix state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         row_ff <= row_in;
         v1_ff  <= vld_i;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      tok1_ff <= tok_i;
      acc1_ff <= acc_i;
      tok2_ff <= tok1_ff;
      acc2_ff <= acc1_ff;
      tok3_ff <= tok2_ff;
      acc3_ff <= acc3_in;
      for (int j = 0; j < su3_pkg::NUM_ROWS; j++) begin
         pa_ff[j]  <= pa_in[j];
         pb_ff[j]  <= pb_in[j];
         pc_ff[j]  <= pc_in[j];
         pd_ff[j]  <= pd_in[j];
         sre_ff[j] <= sre_in[j];
         sim_ff[j] <= sim_in[j];
      end
   end

   assign vld_o = v3_ff;
   assign tok_o = tok3_ff;
   assign acc_o = acc3_ff;

endmodule

FILE: rtl/su3_rsp_fifo.sv
// Result queue between the cell chain and the result channel
module su3_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  su3_pkg::rsp_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output su3_pkg::rsp_type rd_data
);

   su3_pkg::rsp_type mem_ff [su3_pkg::RSP_DEPTH];
   su3_pkg::rsp_type rd_data_ff;
   su3_pkg::ptr_type wr_ptr_ff, wr_ptr_in;
   su3_pkg::ptr_type rd_ptr_ff, rd_ptr_in;
   su3_pkg::cnt_type cnt_ff, cnt_in;
   logic             pop;

   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = rd_data_ff;
   assign pop      = rd_valid && rd_ready;

   // Pointer and fill count; the upstream credit check keeps writes off a full queue
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop   ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + su3_pkg::cnt_type'(wr_en) - su3_pkg::cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage write and registered read of the next head entry; a write into
   // that same slot goes straight through to the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
      if (wr_en && (wr_ptr_ff == rd_ptr_in)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_ptr_in];
      end
   end

endmodule

FILE: rtl/su3_complex_matrix_vector_multiply.sv
// 3x3 complex matrix times complex 3-vector, Q3.20 fixed point.
// req_chan carries requests: cmd load writes matrix row 'row' from a, b, c and
// gives no result; cmd multiply returns M*v, cmd dagger returns M^H*v, where v
// is (a, b, c). Command three and a load of row three are dropped.
// rsp_chan carries one result per multiply request: y1..y3, saturated, and
// last_out echoing last_in. Results leave in request order.
// Request to result: three cells of three stages each (products, pair sums,
// accumulate), then the shift and saturation step into the result queue.
// Throughput: one request per cycle while req_chan.ready is high; the chain of
// three row cells advances every cycle and never stalls.
// Stall: a 16-entry result queue absorbs results while rsp_chan.ready is low;
// req_chan.ready drops once 16 results are queued or in flight.
// Loads travel the chain in order with the other requests, so a multiply
// issued right after a load already sees the new row.
// Reset: the matrix clears to zero, the chain and the queue empty.
module su3_complex_matrix_vector_multiply (
   input  logic         clock,
   input  logic         reset,
   su3_req_if.sink      req_chan,
   su3_rsp_if.source    rsp_chan
);

   logic                 vld_chain [su3_pkg::NUM_ROWS+1];
   su3_pkg::tok_type     tok_chain [su3_pkg::NUM_ROWS+1];
   su3_pkg::acc_vec_type acc_chain [su3_pkg::NUM_ROWS+1];

   su3_pkg::cmd_type     req_cmd;
   logic                 req_take;
   logic                 req_has_rsp;
   logic                 rsp_pop;
   logic                 q_wr;
   su3_pkg::rsp_type     q_wr_data;
   su3_pkg::rsp_type     q_rd_data;
   su3_pkg::cnt_type     outstanding_ff, outstanding_in;

   // Request intake
   assign req_cmd     = su3_pkg::cmd_type'(req_chan.cmd);
   assign req_take    = req_chan.valid && req_chan.ready;
   assign req_has_rsp = (req_cmd == su3_pkg::CMD_MUL) || (req_cmd == su3_pkg::CMD_DAG);

   assign vld_chain[0]       = req_take;
   assign tok_chain[0].cmd   = req_cmd;
   assign tok_chain[0].row   = req_chan.row;
   assign tok_chain[0].vec[0].re = req_chan.a_re;
   assign tok_chain[0].vec[0].im = req_chan.a_im;
   assign tok_chain[0].vec[1].re = req_chan.b_re;
   assign tok_chain[0].vec[1].im = req_chan.b_im;
   assign tok_chain[0].vec[2].re = req_chan.c_re;
   assign tok_chain[0].vec[2].im = req_chan.c_im;
   assign tok_chain[0].last  = req_chan.last_in;
   assign acc_chain[0]       = '0;

   // Chain of row cells
   for (genvar k = 0; k < su3_pkg::NUM_ROWS; k++) begin : g_cell
      su3_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (su3_pkg::row_type'(k)),
         .vld_i    (vld_chain[k]),
         .tok_i    (tok_chain[k]),
         .acc_i    (acc_chain[k]),
         .vld_o    (vld_chain[k+1]),
         .tok_o    (tok_chain[k+1]),
         .acc_o    (acc_chain[k+1])
      );
   end

   // Shift, saturate and queue the finished vector
   always_comb begin
      q_wr = vld_chain[su3_pkg::NUM_ROWS]
          && ((tok_chain[su3_pkg::NUM_ROWS].cmd == su3_pkg::CMD_MUL)
           || (tok_chain[su3_pkg::NUM_ROWS].cmd == su3_pkg::CMD_DAG));
      for (int i = 0; i < su3_pkg::NUM_ROWS; i++) begin
         q_wr_data.y[i].re = su3_pkg::sat_q(acc_chain[su3_pkg::NUM_ROWS][i].re);
         q_wr_data.y[i].im = su3_pkg::sat_q(acc_chain[su3_pkg::NUM_ROWS][i].im);
      end
      q_wr_data.last = tok_chain[su3_pkg::NUM_ROWS].last;
   end

   su3_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_data  (q_wr_data),
      .rd_valid (rsp_chan.valid),
      .rd_ready (rsp_chan.ready),
      .rd_data  (q_rd_data)
   );

   assign rsp_chan.y1_re    = q_rd_data.y[0].re;
   assign rsp_chan.y1_im    = q_rd_data.y[0].im;
   assign rsp_chan.y2_re    = q_rd_data.y[1].re;
   assign rsp_chan.y2_im    = q_rd_data.y[1].im;
   assign rsp_chan.y3_re    = q_rd_data.y[2].re;
   assign rsp_chan.y3_im    = q_rd_data.y[2].im;
   assign rsp_chan.last_out = q_rd_data.last;

   // Credit count: results in flight plus results queued
   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;
   assign outstanding_in = outstanding_ff
                         + su3_pkg::cnt_type'(req_take && req_has_rsp)
                         - su3_pkg::cnt_type'(rsp_pop);
   assign req_chan.ready = (outstanding_ff < su3_pkg::cnt_type'(su3_pkg::RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

endmodule

FILE: rtl/su3_check.sv
// Port-level checks for the matrix-vector block
module su3_check (
   input logic       clock,
   input logic       reset,
   su3_req_if.sink   req_chan,
   su3_rsp_if.source rsp_chan
);

   // Queue is empty right after reset
   a_rsp_idle_after_reset: assert property (
      @(posedge clock) reset |=> !rsp_chan.valid
   ) else $error("result valid right after reset");

   // A result showing on an empty channel comes from a multiply request a fixed
   // pipeline depth earlier
   a_rsp_from_request: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |->
         $past(req_chan.valid && req_chan.ready
               && ((req_chan.cmd == su3_pkg::CMD_MUL) || (req_chan.cmd == su3_pkg::CMD_DAG)),
               su3_pkg::RSP_LATENCY)
   ) else $error("result without matching request");

   // Backpressure on requests only when results are waiting
   a_stall_needs_backlog: assert property (
      @(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid
   ) else $error("request stalled with no result pending");

   // A stalled result holds
   a_rsp_hold: assert property (
      @(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.y1_re) && $stable(rsp_chan.y3_im)
         && $stable(rsp_chan.last_out)
   ) else $error("stalled result changed");

endmodule

bind su3_complex_matrix_vector_multiply su3_check u_su3_check (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
